>>> hdl/dpfr_pkg.sv
// Shared types, sizing constants and the page/offset split for the
// demand-paging frame replacer. No dependencies.

package dpfr_pkg;

  // Sizing of the paging system
  localparam int FRAME_COUNT  = 4;
  localparam int PAGE_COUNT   = 32;
  localparam int PAGE_SIZE    = 10;
  localparam int ACCESS_LIMIT = 320;
  localparam int ADDR_LIMIT   = PAGE_COUNT * PAGE_SIZE;

  // Field widths
  localparam int ADDR_W   = 9;
  localparam int OFFSET_W = 4;
  localparam int FRAME_W  = $clog2(FRAME_COUNT);
  localparam int PAGE_W   = $clog2(PAGE_COUNT);
  localparam int CNT_W    = $clog2(ACCESS_LIMIT + 1);

  // Divide by PAGE_SIZE as a multiply by a rounded-up reciprocal. With the
  // shift at ADDR_W plus log2 of the divisor the quotient is exact for
  // every ADDR_W-bit address.
  localparam int DIV_SHIFT = ADDR_W + $clog2(PAGE_SIZE);
  localparam int RECIP     = ((1 << DIV_SHIFT) + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int RECIP_W   = ADDR_W + 2;
  localparam int PROD_W    = ADDR_W + RECIP_W + PAGE_W;

  // Depth of the queue between the front and back ends
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // One classified access travelling from front to back
  typedef struct packed {
    logic    in_range;
    page_t   page;
    offset_t offset;
  } queue_item_t;

  // One result word from the back end
  typedef struct packed {
    logic    accepted;
    logic    page_hit;
    frame_t  frame_index;
    page_t   page_number;
    offset_t page_offset;
    cnt_t    fault_total;
    cnt_t    access_total;
  } result_t;

  function automatic page_t addr_to_page(input addr_t addr);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(addr) * PROD_W'(RECIP);
    return prod[DIV_SHIFT +: PAGE_W];
  endfunction

endpackage

>>> hdl/dpfr_front.sv
// Front end: splits an instruction address into page and offset and
// checks it against the address range. Depends on dpfr_pkg.

module dpfr_front (
  input  dpfr_pkg::addr_t       instr_address_i,
  output dpfr_pkg::queue_item_t item_o
);
  import dpfr_pkg::*;

  page_t page;
  addr_t page_base;

  assign page      = addr_to_page(instr_address_i);
  assign page_base = ADDR_W'(32'(page) * PAGE_SIZE);

  always_comb begin
    item_o.in_range = (32'(instr_address_i) < 32'(ADDR_LIMIT));
    item_o.page     = page;
    item_o.offset   = OFFSET_W'(instr_address_i - page_base);
  end

endmodule

>>> hdl/dpfr_queue.sv
// Short first-in first-out queue of classified accesses between the
// front and back ends. Depends on dpfr_pkg.

module dpfr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dpfr_pkg::queue_item_t item_i,
  input  logic                  pop_i,
  output dpfr_pkg::queue_item_t item_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import dpfr_pkg::*;

  queue_item_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]        count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> hdl/dpfr_back.sv
// Back end: page table lookup, victim choice, table update, counters and
// the registered result word. Depends on dpfr_pkg.

module dpfr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_policy_i,
  input  logic                  exec_i,
  input  dpfr_pkg::queue_item_t item_i,
  output logic                  result_valid_o,
  output dpfr_pkg::result_t     result_o
);
  import dpfr_pkg::*;

  typedef logic [CNT_W-1:0] stamp_t;

  logic    policy_q;

  logic    map_vld_q [PAGE_COUNT];
  logic    map_vld_d [PAGE_COUNT];
  frame_t  map_frm_q [PAGE_COUNT];
  frame_t  map_frm_d [PAGE_COUNT];
  logic    own_vld_q [FRAME_COUNT];
  logic    own_vld_d [FRAME_COUNT];
  page_t   owner_q   [FRAME_COUNT];
  page_t   owner_d   [FRAME_COUNT];
  stamp_t  last_use_q [FRAME_COUNT];
  stamp_t  last_use_d [FRAME_COUNT];
  stamp_t  load_q    [FRAME_COUNT];
  stamp_t  load_d    [FRAME_COUNT];
  cnt_t    acc_cnt_q, acc_cnt_d;
  cnt_t    flt_cnt_q, flt_cnt_d;

  logic    res_vld_q;
  result_t res_q, res_d;

  logic    serve;
  logic    hit;
  frame_t  hit_frame;
  frame_t  victim;
  logic    found_empty;
  stamp_t  best_stamp;
  stamp_t  cur_stamp;

  assign serve     = item_i.in_range && (acc_cnt_q < CNT_W'(ACCESS_LIMIT));
  assign hit       = map_vld_q[item_i.page];
  assign hit_frame = map_frm_q[item_i.page];

  // Victim: lowest empty frame, else oldest stamp with lowest index on ties
  always_comb begin
    victim      = '0;
    found_empty = 1'b0;
    best_stamp  = policy_q ? load_q[0] : last_use_q[0];
    cur_stamp   = '0;
    for (int f = 0; f < FRAME_COUNT; f++) begin
      if (!found_empty && !own_vld_q[f]) begin
        victim      = FRAME_W'(f);
        found_empty = 1'b1;
      end
    end
    if (!found_empty) begin
      for (int f = 1; f < FRAME_COUNT; f++) begin
        cur_stamp = policy_q ? load_q[f] : last_use_q[f];
        if (cur_stamp < best_stamp) begin
          best_stamp = cur_stamp;
          victim     = FRAME_W'(f);
        end
      end
    end
  end

  always_comb begin
    map_vld_d  = map_vld_q;
    map_frm_d  = map_frm_q;
    own_vld_d  = own_vld_q;
    owner_d    = owner_q;
    last_use_d = last_use_q;
    load_d     = load_q;
    acc_cnt_d  = acc_cnt_q;
    flt_cnt_d  = flt_cnt_q;
    res_d      = '0;
    res_d.fault_total  = flt_cnt_q;
    res_d.access_total = acc_cnt_q;

    if (exec_i && serve) begin
      acc_cnt_d = acc_cnt_q + 1'b1;
      res_d.accepted     = 1'b1;
      res_d.page_hit     = hit;
      res_d.page_number  = item_i.page;
      res_d.page_offset  = item_i.offset;
      res_d.access_total = acc_cnt_q + 1'b1;
      if (hit) begin
        last_use_d[hit_frame] = acc_cnt_q;
        res_d.frame_index     = hit_frame;
      end else begin
        flt_cnt_d = flt_cnt_q + 1'b1;
        res_d.fault_total = flt_cnt_q + 1'b1;
        res_d.frame_index = victim;
        if (own_vld_q[victim]) begin
          map_vld_d[owner_q[victim]] = 1'b0;
        end
        own_vld_d[victim]       = 1'b1;
        owner_d[victim]         = item_i.page;
        last_use_d[victim]      = acc_cnt_q;
        load_d[victim]          = acc_cnt_q;
        map_vld_d[item_i.page]  = 1'b1;
        map_frm_d[item_i.page]  = victim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= 1'b0;
      acc_cnt_q <= '0;
      flt_cnt_q <= '0;
      res_vld_q <= 1'b0;
      for (int p = 0; p < PAGE_COUNT; p++) begin
        map_vld_q[p] <= 1'b0;
      end
      for (int f = 0; f < FRAME_COUNT; f++) begin
        own_vld_q[f] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        policy_q <= cfg_policy_i;
      end
      acc_cnt_q <= acc_cnt_d;
      flt_cnt_q <= flt_cnt_d;
      res_vld_q <= exec_i;
      map_vld_q <= map_vld_d;
      own_vld_q <= own_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    map_frm_q  <= map_frm_d;
    owner_q    <= owner_d;
    last_use_q <= last_use_d;
    load_q     <= load_d;
    if (exec_i) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

>>> hdl/demand_paging_frame_replacer.sv
// Top level of the demand-paging frame replacer: front end, queue and
// back end. Depends on dpfr_pkg, dpfr_front, dpfr_queue and dpfr_back.
//
//  Channel  | Direction | Handshake                    | Word
//  ---------+-----------+------------------------------+------------------------------
//  access   | in        | start_i high, busy_o low     | instr_address_i
//  result   | out       | result_valid_o, one cycle    | accepted_o .. access_total_o
//  config   | in        | cfg_valid_i and cfg_ready_o  | cfg_policy_select_i
//
// A word accepted at one clock edge enters the queue; the back end takes it
// in the following cycle and its result is shown for exactly one cycle
// after the next edge. The back end drains one word per cycle, so the queue
// never holds more than one word and busy_o stays low: a new access may be
// offered every cycle. The receiver cannot stall the result channel. Reset
// is asynchronous and active low; it empties the page table and all frames
// at once through per-entry valid bits, so there is no clearing pass. The
// policy register is writable whenever the queue is empty.

module demand_paging_frame_replacer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  dpfr_pkg::addr_t         instr_address_i,
  output logic                    result_valid_o,
  output logic                    accepted_o,
  output logic                    page_hit_o,
  output dpfr_pkg::frame_t        frame_index_o,
  output dpfr_pkg::page_t         page_number_o,
  output dpfr_pkg::offset_t       page_offset_o,
  output dpfr_pkg::cnt_t          fault_total_o,
  output dpfr_pkg::cnt_t          access_total_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_policy_select_i
);
  import dpfr_pkg::*;

  queue_item_t front_item;
  queue_item_t back_item;
  logic        q_empty;
  logic        q_full;
  logic        push;
  logic        exec;
  result_t     result;

  // An access is taken whenever the queue has room.
  assign busy_o      = q_full;
  assign push        = start_i && !q_full;
  // The back end runs whenever the queue holds a word.
  assign exec        = !q_empty;
  // Configuration is only taken with nothing waiting in the queue.
  assign cfg_ready_o = q_empty;

  dpfr_front u_front (
    .instr_address_i (instr_address_i),
    .item_o          (front_item)
  );

  dpfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (exec),
    .item_o  (back_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  dpfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_policy_i   (cfg_policy_select_i),
    .exec_i         (exec),
    .item_i         (back_item),
    .result_valid_o (result_valid_o),
    .result_o       (result)
  );

  assign accepted_o     = result.accepted;
  assign page_hit_o     = result.page_hit;
  assign frame_index_o  = result.frame_index;
  assign page_number_o  = result.page_number;
  assign page_offset_o  = result.page_offset;
  assign fault_total_o  = result.fault_total;
  assign access_total_o = result.access_total;

`ifndef SYNTHESIS
  // Every fault is also a served access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (fault_total_o <= access_total_o))
    else $error("fault count exceeds access count");

  // A refused access reports no hit and no frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !accepted_o) |-> (!page_hit_o && frame_index_o == '0))
    else $error("refused access carries mapping data");

  // The served count never passes the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (access_total_o <= CNT_W'(ACCESS_LIMIT)))
    else $error("access count beyond limit");

  // A word taken with an empty queue passes queue and result register to a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cfg_ready_o) |-> ##2 result_valid_o)
    else $error("result missing after accepted access");
`endif

endmodule
